// ===== rtl/mi3_pkg.sv =====
package mi3_pkg;

    localparam int ENTRY_WIDTH_DEF = 24;
    localparam int NUM_ENTRIES     = 9;
    localparam int OUT_WIDTH       = 32;
    // Quotient bits kept by the divider: bit 32 down to bit 0.
    localparam int QBITS           = 33;

    typedef struct packed {
        logic valid;
        logic singular;
    } mi3_ctrl_t;

endpackage

// ===== rtl/matrix_inverse_3x3_core.sv =====
// Inverse of a 3x3 matrix by adjugate over determinant, one matrix a beat.
// Pipeline: 2 cofactor stages, 3 determinant stages, 33 divider stages of one
// quotient bit each, then 1 output register.
// Throughput: one matrix per cycle; the whole pipeline stalls while the output is held.
// Reset: synchronous active-low aresetn clears all valid bits; no results are pending.
module matrix_inverse_3x3_core #(
    parameter int ENTRY_WIDTH = mi3_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // in_r0c0, in_r0c1, in_r0c2, in_r1c0 .. in_r2c2, ENTRY_WIDTH bits each, then zero fill
    input  logic [((9*ENTRY_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // out_r0c0, out_r0c1, out_r0c2, out_r1c0 .. out_r2c2, 32 bits each
    output logic [9*mi3_pkg::OUT_WIDTH-1:0]        m_axis_tdata,
    // singular
    output logic                                   m_axis_tuser
);

    localparam int W  = ENTRY_WIDTH;
    localparam int N  = mi3_pkg::NUM_ENTRIES;
    localparam int OW = mi3_pkg::OUT_WIDTH;
    localparam int QB = mi3_pkg::QBITS;

    logic                 en;
    logic signed [W-1:0]  m_in [N];
    logic                 cof_valid;
    logic signed [2*W:0]  cof [N];
    logic signed [W-1:0]  row0 [3];
    mi3_pkg::mi3_ctrl_t   det_ctrl, div_ctrl;
    logic [3*W-1:0]       dmag;
    logic [2*W-1:0]       cmag [N];
    logic                 qneg [N];
    logic [QB-1:0]        quo [N];
    logic                 neg [N];
    logic                 ovf [N];
    logic                 valid_reg;
    logic [N*OW-1:0]      data_reg, data_next;
    logic                 sing_reg;

    assign en            = !valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    for (genvar k = 0; k < N; k++) begin : g_in
        assign m_in[k] = $signed(s_axis_tdata[k*W +: W]);
    end

    mi3_cofactor #(.W(W)) u_cof (
        .aclk, .aresetn, .en,
        .in_valid (s_axis_tvalid),
        .m        (m_in),
        .out_valid(cof_valid),
        .cof      (cof),
        .row0     (row0)
    );

    mi3_det #(.W(W)) u_det (
        .aclk, .aresetn, .en,
        .in_valid(cof_valid),
        .cof     (cof),
        .row0    (row0),
        .ctrl    (det_ctrl),
        .dmag    (dmag),
        .cmag    (cmag),
        .qneg    (qneg)
    );

    mi3_divider #(.W(W)) u_div (
        .aclk, .aresetn, .en,
        .in_ctrl (det_ctrl),
        .dmag    (dmag),
        .cmag    (cmag),
        .qneg    (qneg),
        .out_ctrl(div_ctrl),
        .quo     (quo),
        .neg     (neg),
        .ovf     (ovf)
    );

    // Zero every entry of a singular matrix; else saturate and apply the sign of each quotient.
    always_comb begin
        data_next = '0;
        for (int k = 0; k < N; k++) begin
            if (div_ctrl.singular) begin
                data_next[k*OW +: OW] = '0;
            end else if (neg[k]) begin
                if (ovf[k] || quo[k] > QB'(33'h080000000)) begin
                    data_next[k*OW +: OW] = 32'h80000000;
                end else begin
                    data_next[k*OW +: OW] = OW'(-quo[k]);
                end
            end else begin
                if (ovf[k] || quo[k] > QB'(33'h07FFFFFFF)) begin
                    data_next[k*OW +: OW] = 32'h7FFFFFFF;
                end else begin
                    data_next[k*OW +: OW] = quo[k][OW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= div_ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
            sing_reg <= div_ctrl.singular;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = sing_reg;

    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("singular result with nonzero entries");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        en && div_ctrl.valid |=> m_axis_tvalid)
        else $error("divider result lost at output register");

endmodule

// ===== rtl/mi3_cofactor.sv =====
module mi3_cofactor #(
    parameter int W = mi3_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [W-1:0] m [mi3_pkg::NUM_ENTRIES],
    output logic                out_valid,
    output logic signed [2*W:0] cof [mi3_pkg::NUM_ENTRIES],
    output logic signed [W-1:0] row0 [3]
);

    // Each cofactor is m[A]*m[B] - m[C]*m[D], entries indexed row-major.
    localparam int IA [9] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
    localparam int IB [9] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
    localparam int IC [9] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
    localparam int ID [9] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

    logic                  v1_reg, v2_reg;
    logic signed [2*W-1:0] pa_reg [9];
    logic signed [2*W-1:0] pb_reg [9];
    logic signed [W-1:0]   r1_reg [3];
    logic signed [2*W:0]   cof_reg [9];
    logic signed [W-1:0]   r2_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                pa_reg[k]  <= m[IA[k]] * m[IB[k]];
                pb_reg[k]  <= m[IC[k]] * m[ID[k]];
                cof_reg[k] <= $signed({pa_reg[k][2*W-1], pa_reg[k]})
                            - $signed({pb_reg[k][2*W-1], pb_reg[k]});
            end
            for (int k = 0; k < 3; k++) begin
                r1_reg[k] <= m[k];
                r2_reg[k] <= r1_reg[k];
            end
        end
    end

    assign out_valid = v2_reg;
    assign cof       = cof_reg;
    assign row0      = r2_reg;

endmodule

// ===== rtl/mi3_det.sv =====
module mi3_det #(
    parameter int W = mi3_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [2*W:0]   cof [mi3_pkg::NUM_ENTRIES],
    input  logic signed [W-1:0]   row0 [3],
    output mi3_pkg::mi3_ctrl_t    ctrl,
    output logic [3*W-1:0]        dmag,
    output logic [2*W-1:0]        cmag [mi3_pkg::NUM_ENTRIES],
    output logic                  qneg [mi3_pkg::NUM_ENTRIES]
);

    localparam int DW = 3*W + 1;

    // Lane r*3+c carries cofactor C[c][r], so the lanes come out as the adjugate.
    localparam int TR [9] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

    logic                 v3_reg, v4_reg, v5_reg;
    logic signed [2*W:0]  pl_reg [3];
    logic signed [2*W:0]  ph_reg [3];
    logic signed [2*W:0]  c3_reg [9];
    logic signed [DW-1:0] det_reg;
    logic signed [2*W:0]  c4_reg [9];
    logic                 sing_reg;
    logic [3*W-1:0]       dmag_reg;
    logic [2*W-1:0]       cmag_reg [9];
    logic                 qneg_reg [9];
    logic signed [DW-1:0] det_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Row 0 times its cofactors, each split into a low unsigned and a high signed half.
    always_comb begin
        det_next = '0;
        for (int k = 0; k < 3; k++) begin
            det_next = det_next + $signed({ph_reg[k], {W{1'b0}}})
                     + $signed({{W{pl_reg[k][2*W]}}, pl_reg[k]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                pl_reg[k] <= row0[k] * $signed({1'b0, cof[k][W-1:0]});
                ph_reg[k] <= row0[k] * $signed(cof[k][2*W:W]);
            end
            c3_reg   <= cof;
            det_reg  <= det_next;
            c4_reg   <= c3_reg;
            sing_reg <= (det_reg == '0);
            dmag_reg <= det_reg[DW-1] ? (3*W)'(-det_reg) : det_reg[3*W-1:0];
            for (int k = 0; k < 9; k++) begin
                cmag_reg[k] <= c4_reg[TR[k]][2*W] ? (2*W)'(-c4_reg[TR[k]])
                                                  : c4_reg[TR[k]][2*W-1:0];
                qneg_reg[k] <= c4_reg[TR[k]][2*W] ^ det_reg[DW-1];
            end
        end
    end

    assign ctrl.valid    = v5_reg;
    assign ctrl.singular = sing_reg;
    assign dmag          = dmag_reg;
    assign cmag          = cmag_reg;
    assign qneg          = qneg_reg;

endmodule

// ===== rtl/mi3_divider.sv =====
module mi3_divider #(
    parameter int W = mi3_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  mi3_pkg::mi3_ctrl_t               in_ctrl,
    input  logic [3*W-1:0]                   dmag,
    input  logic [2*W-1:0]                   cmag [mi3_pkg::NUM_ENTRIES],
    input  logic                             qneg [mi3_pkg::NUM_ENTRIES],
    output mi3_pkg::mi3_ctrl_t               out_ctrl,
    output logic [mi3_pkg::QBITS-1:0]        quo [mi3_pkg::NUM_ENTRIES],
    output logic                             neg [mi3_pkg::NUM_ENTRIES],
    output logic                             ovf [mi3_pkg::NUM_ENTRIES]
);

    localparam int QB = mi3_pkg::QBITS;
    localparam int RW = 3*W;

    mi3_pkg::mi3_ctrl_t ctrl_reg [QB];
    logic [RW-1:0]      d_reg    [QB];
    logic [RW-1:0]      rem_reg  [QB][9];
    logic [QB-1:0]      q_reg    [QB][9];
    logic               neg_reg  [QB][9];
    logic               ovf_reg  [QB][9];

    // First step: the quotient must stay below 2^33, so the numerator's top part
    // must be below twice the divisor; otherwise the entry saturates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg[0] <= '0;
        end else if (en) begin
            ctrl_reg[0] <= in_ctrl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg[0] <= dmag;
            for (int k = 0; k < 9; k++) begin
                ovf_reg[0][k] <= {(RW+2)'(cmag[k])} >= {1'b0, dmag, 1'b0};
                neg_reg[0][k] <= qneg[k];
                if (RW'(cmag[k]) >= dmag) begin
                    q_reg[0][k]   <= QB'(1);
                    rem_reg[0][k] <= RW'(cmag[k]) - dmag;
                end else begin
                    q_reg[0][k]   <= '0;
                    rem_reg[0][k] <= RW'(cmag[k]);
                end
            end
        end
    end

    for (genvar s = 1; s < QB; s++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctrl_reg[s] <= '0;
            end else if (en) begin
                ctrl_reg[s] <= ctrl_reg[s-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[s] <= d_reg[s-1];
                for (int k = 0; k < 9; k++) begin
                    neg_reg[s][k] <= neg_reg[s-1][k];
                    ovf_reg[s][k] <= ovf_reg[s-1][k];
                    if ({rem_reg[s-1][k], 1'b0} >= {1'b0, d_reg[s-1]}) begin
                        rem_reg[s][k] <= RW'({rem_reg[s-1][k], 1'b0} - {1'b0, d_reg[s-1]});
                        q_reg[s][k]   <= {q_reg[s-1][k][QB-2:0], 1'b1};
                    end else begin
                        rem_reg[s][k] <= {rem_reg[s-1][k][RW-2:0], 1'b0};
                        q_reg[s][k]   <= {q_reg[s-1][k][QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign out_ctrl = ctrl_reg[QB-1];
    assign quo      = q_reg[QB-1];
    assign neg      = neg_reg[QB-1];
    assign ovf      = ovf_reg[QB-1];

endmodule
